// ===== src/c3lb_pkg.sv =====
// Shared types, constants and register codes of the 3x3 line buffer filter.
// No dependencies; c3lb_cell and conv3x3_line_buffer_filter import this package.
package c3lb_pkg;

    localparam int MAX_LINE_WIDTH_DEF = 128;
    localparam int COEF_BITS_DEF      = 8;
    localparam int HEIGHT_MAX         = 4096;
    localparam int PIX_MAX            = 255;

    localparam int PIX_W      = 8;
    localparam int COL_W      = 8;
    localparam int ROW_W      = 12;
    localparam int HGT_W      = 13;
    localparam int KROW_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [COL_W-1:0] WIDTH_RESET  = 8'd128;
    localparam logic [HGT_W-1:0] HEIGHT_RESET = 13'd128;

    typedef logic [PIX_W-1:0] t_pixel;

    // One window column: [0] top line, [1] middle line, [2] current line.
    typedef t_pixel [2:0] t_pix_col;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_KERNEL_TOP    = 3'd2,
        CFG_KERNEL_MIDDLE = 3'd3,
        CFG_KERNEL_BOTTOM = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic shift;   // load a new column, pass own column to the left
        logic adv;     // advance the product and sum stages
    } t_cell_ctrl;

endpackage

// ===== src/c3lb_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Read-first on a same-address collision. Depends on nothing.
module c3lb_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/c3lb_cell.sv =====
// One window column cell: holds three pixels, weights them by its kernel
// column and registers the column sum. Depends on c3lb_pkg.
module c3lb_cell import c3lb_pkg::*; #(
    parameter int COEF_BITS = COEF_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cell_ctrl                     i_ctrl,
    input  t_pix_col                       i_col,
    input  logic [2:0][COEF_BITS-1:0]      i_coef,
    output t_pix_col                       o_col,
    output logic signed [COEF_BITS+10:0]   o_sum
);

    localparam int PROD_W = COEF_BITS + 9;
    localparam int SUM_W  = PROD_W + 2;

    t_pix_col                  r_px;
    logic signed [PROD_W-1:0]  r_prod [3];
    logic signed [PROD_W-1:0]  n_prod [3];
    logic signed [SUM_W-1:0]   r_sum;
    logic signed [SUM_W-1:0]   n_sum;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_prod[k] = PROD_W'($signed({1'b0, r_px[k]})) * PROD_W'($signed(i_coef[k]));
        end
        n_sum = SUM_W'(r_prod[0]) + SUM_W'(r_prod[1]) + SUM_W'(r_prod[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= '0;
        end else if (i_ctrl.shift) begin
            r_px <= i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.adv) begin
            r_prod <= n_prod;
            r_sum  <= n_sum;
        end
    end

    assign o_col = r_px;
    assign o_sum = r_sum;

endmodule

// ===== src/conv3x3_line_buffer_filter.sv =====
// Throughput: one pixel per clock while the output queue has a free entry; each pixel
// reads both line stores and is written to the store of the older line, and the window
// cells step once per pixel. A 2-entry output queue keeps input taking pixels while a
// result waits. Reset (synchronous, active low) restores the register defaults and
// clears counters, window and pipeline valid flags; line stores are not cleared.
// Depends on c3lb_pkg, c3lb_ram and c3lb_cell.
module conv3x3_line_buffer_filter import c3lb_pkg::*; #(
    parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF,
    parameter int COEF_BITS      = COEF_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write port
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    // pixel input stream
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [7:0]              s_axis_tdata,   // [7:0] pixel_in
    // filtered pixel output stream
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [7:0]              m_axis_tdata,   // [7:0] pixel_out
    output logic                    m_axis_tlast    // frame_last
);

    localparam int ADDR_W = $clog2(MAX_LINE_WIDTH);
    localparam int SUM_W  = COEF_BITS + 11;
    localparam int TOT_W  = SUM_W + 2;
    localparam int KEXT_W = (3 * COEF_BITS > KROW_W) ? 3 * COEF_BITS : KROW_W;

    // ---------------------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------------------
    logic [COL_W-1:0]  r_image_width;
    logic [HGT_W-1:0]  r_image_height;
    logic [KROW_W-1:0] r_kernel [3];   // [0] top, [1] middle, [2] bottom

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WIDTH_RESET;
            r_image_height <= HEIGHT_RESET;
            r_kernel[0]    <= '0;
            r_kernel[1]    <= '0;
            r_kernel[2]    <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_IMAGE_WIDTH:   r_image_width  <= i_cfg_data[COL_W-1:0];
                CFG_IMAGE_HEIGHT:  r_image_height <= i_cfg_data[HGT_W-1:0];
                CFG_KERNEL_TOP:    r_kernel[0]    <= i_cfg_data[KROW_W-1:0];
                CFG_KERNEL_MIDDLE: r_kernel[1]    <= i_cfg_data[KROW_W-1:0];
                CFG_KERNEL_BOTTOM: r_kernel[2]    <= i_cfg_data[KROW_W-1:0];
                default: ;   // drop writes to unused indexes
            endcase
        end
    end

    // Saturate the frame size to the supported range.
    logic [COL_W-1:0] w_width;
    logic [HGT_W-1:0] w_height;

    always_comb begin
        if (r_image_width < COL_W'(3)) begin
            w_width = COL_W'(3);
        end else if (32'(r_image_width) > 32'(MAX_LINE_WIDTH)) begin
            w_width = COL_W'(MAX_LINE_WIDTH);
        end else begin
            w_width = r_image_width;
        end
        if (r_image_height < HGT_W'(3)) begin
            w_height = HGT_W'(3);
        end else if (r_image_height > HGT_W'(HEIGHT_MAX)) begin
            w_height = HGT_W'(HEIGHT_MAX);
        end else begin
            w_height = r_image_height;
        end
    end

    // ---------------------------------------------------------------------------------
    // Output queue and pipeline advance. The pipeline moves whenever the queue has a
    // free entry, so input readiness does not depend combinationally on the downstream ready.
    // ---------------------------------------------------------------------------------
    logic [1:0] r_q_count;
    logic       r_q_wr_ptr;
    logic       r_q_rd_ptr;
    t_pixel     r_q_pix  [2];
    logic       r_q_last [2];
    logic       w_adv;
    logic       w_accept;
    logic       w_push;
    logic       w_pop;

    assign w_adv         = (r_q_count != 2'd2);
    assign s_axis_tready = w_adv;
    assign w_accept      = s_axis_tvalid && w_adv;

    // ---------------------------------------------------------------------------------
    // Stage 0: position counters, line store access
    // ---------------------------------------------------------------------------------
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic             r_older;   // slot holding the older of the two stored lines
    logic             w_last_col;
    logic             w_last_row;
    logic             w_in_store;
    logic             w_result;

    assign w_last_col = (9'(r_col) + 9'd1) >= 9'(w_width);
    assign w_last_row = (HGT_W'(r_row) + HGT_W'(1)) >= w_height;
    assign w_in_store = 32'(r_col) < 32'(MAX_LINE_WIDTH);
    assign w_result   = (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_older <= 1'b0;
        end else if (w_accept) begin
            if (w_last_col) begin
                // wrap the column, rotate the line slots, step or wrap the row
                r_col   <= '0;
                r_older <= ~r_older;
                r_row   <= w_last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    t_pixel w_rd_data [2];

    for (genvar s = 0; s < 2; s++) begin : g_line
        c3lb_ram #(
            .DATA_W (PIX_W),
            .DEPTH  (MAX_LINE_WIDTH)
        ) u_line_store (
            .i_clk     (i_clk),
            .i_we      (w_accept && w_in_store && (r_older == 1'(s))),
            .i_wr_addr (ADDR_W'(r_col)),
            .i_wr_data (s_axis_tdata),
            .i_rd_en   (w_accept),
            .i_rd_addr (ADDR_W'(r_col)),
            .o_rd_data (w_rd_data[s])
        );
    end

    // ---------------------------------------------------------------------------------
    // Stage 1: line store data arrives, build the new window column
    // ---------------------------------------------------------------------------------
    logic   r_s1_valid;
    logic   r_s1_res;
    logic   r_s1_last;
    t_pixel r_s1_pix;
    logic   r_s1_top_ok;
    logic   r_s1_mid_ok;
    logic   r_s1_older;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_res    <= w_result;
            r_s1_last   <= w_last_col && w_last_row;
            r_s1_pix    <= s_axis_tdata;
            r_s1_top_ok <= w_in_store && (r_row >= ROW_W'(2));
            r_s1_mid_ok <= w_in_store && (r_row >= ROW_W'(1));
            r_s1_older  <= r_older;
        end
    end

    t_pix_col w_new_col;

    always_comb begin
        // rows above the frame start read as zero
        w_new_col[0] = r_s1_top_ok ? w_rd_data[r_s1_older]  : '0;
        w_new_col[1] = r_s1_mid_ok ? w_rd_data[~r_s1_older] : '0;
        w_new_col[2] = r_s1_pix;
    end

    // ---------------------------------------------------------------------------------
    // Stages 2..4: chain of window cells. Cell 2 takes the new column, cells 1 and 0
    // take their right neighbor's column, so the three cells hold columns c-2..c.
    // Each cell weights its column and registers the column sum.
    // ---------------------------------------------------------------------------------
    t_cell_ctrl                 w_cell_ctrl;
    t_pix_col                   w_cell_col [3];
    logic signed [SUM_W-1:0]    w_cell_sum [3];
    logic [KEXT_W-1:0]          w_kernel_ext [3];
    logic [2:0][COEF_BITS-1:0]  w_coef [3];

    always_comb begin
        w_cell_ctrl.shift = w_adv && r_s1_valid;
        w_cell_ctrl.adv   = w_adv;
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_kernel_ext[r] = KEXT_W'(r_kernel[r]);
        end
        for (int k = 0; k < 3; k++) begin
            for (int r = 0; r < 3; r++) begin
                w_coef[k][r] = w_kernel_ext[r][k*COEF_BITS +: COEF_BITS];
            end
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_cell
        c3lb_cell #(
            .COEF_BITS (COEF_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_cell_ctrl),
            .i_col   ((k == 2) ? w_new_col : w_cell_col[(k + 1) % 3]),
            .i_coef  (w_coef[k]),
            .o_col   (w_cell_col[k]),
            .o_sum   (w_cell_sum[k])
        );
    end

    // Result flags follow the cell stages.
    logic [2:0] r_res_pipe;    // [0] window, [1] products, [2] column sums
    logic [2:0] r_last_pipe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_pipe <= '0;
        end else if (w_adv) begin
            r_res_pipe <= {r_res_pipe[1:0], r_s1_valid && r_s1_res};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_last_pipe <= {r_last_pipe[1:0], r_s1_last};
        end
    end

    // Total of the three column sums, clamped to the pixel range.
    logic signed [TOT_W-1:0] w_total;
    t_pixel                  w_clamped;

    always_comb begin
        w_total = TOT_W'(w_cell_sum[0]) + TOT_W'(w_cell_sum[1]) + TOT_W'(w_cell_sum[2]);
        if (w_total < $signed(TOT_W'(0))) begin
            w_clamped = '0;
        end else if (w_total > $signed(TOT_W'(PIX_MAX))) begin
            w_clamped = PIX_W'(PIX_MAX);
        end else begin
            w_clamped = w_total[PIX_W-1:0];
        end
    end

    // ---------------------------------------------------------------------------------
    // Output queue
    // ---------------------------------------------------------------------------------
    assign w_push = w_adv && r_res_pipe[2];
    assign w_pop  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_count  <= '0;
            r_q_wr_ptr <= 1'b0;
            r_q_rd_ptr <= 1'b0;
        end else begin
            if (w_push) begin
                r_q_wr_ptr <= ~r_q_wr_ptr;
            end
            if (w_pop) begin
                r_q_rd_ptr <= ~r_q_rd_ptr;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_q_count <= r_q_count + 2'd1;
                2'b01:   r_q_count <= r_q_count - 2'd1;
                default: r_q_count <= r_q_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_pix[r_q_wr_ptr]  <= w_clamped;
            r_q_last[r_q_wr_ptr] <= r_last_pipe[2];
        end
    end

    assign m_axis_tvalid = (r_q_count != 2'd0);
    assign m_axis_tdata  = r_q_pix[r_q_rd_ptr];
    assign m_axis_tlast  = r_q_last[r_q_rd_ptr];

endmodule
